// ===== rtl/core/rolling_hash_mersenne61_macros.svh =====
// Assertion macros for the rolling hash checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ROLLING_HASH_MERSENNE61_MACROS_SVH
`define ROLLING_HASH_MERSENNE61_MACROS_SVH

// same-cycle implication
`define RHM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rolling hash check failed");

// next-cycle implication
`define RHM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rolling hash check failed");

`endif

// ===== rtl/core/rhm61_pkg.sv =====
// Shared types, constants and the mod 2^61-1 fold for the rolling hash block.
// No dependencies.
package rhm61_pkg;

  localparam int unsigned RHM_MAX_LEN = 4096;
  localparam int unsigned WORD_W      = 61;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t PRIME_M61  = {WORD_W{1'b1}};
  localparam word_t BASE_RESET = word_t'(131);

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MSEL_BASE_PREFIX  = 2'd0,
    MSEL_POWER_BASE   = 2'd1,
    MSEL_PREFIX_POWER = 2'd2
  } msel_e;

  // controller -> datapath
  typedef struct packed {
    logic  cap;
    logic  rd;
    logic  mul_start;
    msel_e mul_sel;
    logic  res_append;
    logic  res_query;
    logic  res_zero;
    logic  wr_power;
    logic  clr_len;
    logic  out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] kind;
    logic       bad;
    logic       mul_done;
    logic       out_free;
  } sts_t;

  // reduce v (top bits at most 7) into [0, P)
  function automatic word_t fold61(input logic [63:0] v);
    logic [WORD_W:0] r;
    r = {{(WORD_W-2){1'b0}}, v[63:61]} + {1'b0, v[WORD_W-1:0]};
    if (r >= {1'b0, PRIME_M61}) begin
      r = r - {1'b0, PRIME_M61};
    end
    return r[WORD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/rhm61_mul.sv =====
// Iterative 61x61 modular multiplier mod 2^61-1: one 31x31 partial product per cycle.
// Depends on rhm61_pkg.
module rhm61_mul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  rhm61_pkg::word_t x_i,
  input  rhm61_pkg::word_t y_i,
  output logic            done_o,
  output rhm61_pkg::word_t prod_o
);
  import rhm61_pkg::*;

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_HL = 2'd1;
  localparam logic [1:0] STEP_LH = 2'd2;
  localparam logic [1:0] STEP_HH = 2'd3;

  word_t       x_q, y_q, acc_q;
  logic [1:0]  step_q, pstep_q;
  logic        busy_q, pv_q, done_q;
  logic [61:0] prod_q, prod_d;
  logic [30:0] opa, opb;
  logic [63:0] term;

  always_comb begin
    unique case (step_q)
      STEP_LL: begin opa = x_q[30:0];          opb = y_q[30:0];          end
      STEP_HL: begin opa = {1'b0, x_q[60:31]}; opb = y_q[30:0];          end
      STEP_LH: begin opa = x_q[30:0];          opb = {1'b0, y_q[60:31]}; end
      default: begin opa = {1'b0, x_q[60:31]}; opb = {1'b0, y_q[60:31]}; end
    endcase
  end

  assign prod_d = {31'b0, opa} * {31'b0, opb};

  // weight 2^31 splits at bit 30, weight 2^62 folds to a factor of two
  always_comb begin
    unique case (pstep_q)
      STEP_LL: term = {2'b0, prod_q};
      STEP_HL,
      STEP_LH: term = {3'b0, prod_q[29:0], 31'b0} + {32'b0, prod_q[61:30]};
      default: term = {1'b0, prod_q, 1'b0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= STEP_LL;
      pv_q    <= 1'b0;
      pstep_q <= STEP_LL;
      done_q  <= 1'b0;
    end else begin
      done_q <= pv_q && (pstep_q == STEP_HH);
      pv_q   <= busy_q;
      if (busy_q) begin
        pstep_q <= step_q;
        step_q  <= step_q + 2'd1;
        if (step_q == STEP_HH) begin
          busy_q <= 1'b0;
        end
      end
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_LL;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= fold61({3'b0, acc_q} + term);
    end
    if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/core/rhm61_ctrl.sv =====
// Sequencing state machine for the rolling hash block.
// Depends on rhm61_pkg; drives the datapath through cmd_t, watches sts_t.
module rhm61_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rhm61_pkg::sts_t  sts_i,
  output rhm61_pkg::cmd_t  cmd_o
);
  import rhm61_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_M1     = 3'd2;
  localparam logic [2:0] S_W1     = 3'd3;
  localparam logic [2:0] S_M2     = 3'd4;
  localparam logic [2:0] S_W2     = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       is_append;

  assign is_append = (sts_i.kind == KIND_APPEND);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MSEL_BASE_PREFIX;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        if (sts_i.bad) begin
          cmd_o.res_zero = 1'b1;
        end else begin
          unique case (sts_i.kind)
            KIND_APPEND, KIND_QUERY: begin
              cmd_o.rd = 1'b1;
              state_d  = S_M1;
            end
            KIND_RESTART: begin
              cmd_o.clr_len  = 1'b1;
              cmd_o.res_zero = 1'b1;
            end
            default: cmd_o.res_zero = 1'b1;
          endcase
        end
      end
      S_M1: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = is_append ? MSEL_BASE_PREFIX : MSEL_PREFIX_POWER;
        state_d         = S_W1;
      end
      S_W1: begin
        if (sts_i.mul_done) begin
          if (is_append) begin
            cmd_o.res_append = 1'b1;
            state_d          = S_M2;
          end else begin
            cmd_o.res_query = 1'b1;
            state_d         = S_DONE;
          end
        end
      end
      S_M2: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_POWER_BASE;
        state_d         = S_W2;
      end
      S_W2: begin
        if (sts_i.mul_done) begin
          cmd_o.wr_power = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== rtl/core/rhm61_dp.sv =====
// Datapath: base register, length counter, prefix and power memories, multiplier,
// result and output registers. Depends on rhm61_pkg and rhm61_mul.
module rhm61_dp #(
  parameter int unsigned MAX_LEN = rhm61_pkg::RHM_MAX_LEN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rhm61_pkg::cmd_t  cmd_i,
  output rhm61_pkg::sts_t  sts_o,
  input  logic             cfg_valid_i,
  input  rhm61_pkg::word_t cfg_data_i,
  input  logic [1:0]       kind_i,
  input  logic [7:0]       byte_i,
  input  logic [12:0]      start_i,
  input  logic [12:0]      length_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output rhm61_pkg::word_t out_hash_o,
  output logic             out_err_o
);
  import rhm61_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_LEN + 1);
  localparam int unsigned SumW = (LenW > 14) ? LenW : 14;

  word_t base_q;
  logic [LenW-1:0] len_q, wr_addr;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic [12:0] start_q, length_q;
  logic [SumW-1:0] end_pos;
  logic        bad;

  word_t prefix_mem [0:MAX_LEN];
  word_t power_mem  [0:MAX_LEN];
  logic [LenW-1:0] lo_addr, hi_addr, pw_addr;
  word_t lo_raw_q, hi_raw_q, pw_raw_q;
  logic  lo_zero_q, hi_zero_q, pw_zero_q;
  word_t pre_lo, pre_hi, pow;

  word_t mul_x, mul_y, mul_p;
  logic  mul_done;
  word_t fin_append, fin_query;

  word_t res_q;
  logic  res_err_q;
  logic  out_valid_q, out_err_q;
  word_t out_hash_q;

  // configuration: P itself reduces to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_valid_i) begin
      base_q <= (cfg_data_i == PRIME_M61) ? '0 : cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q   <= kind_i;
      byte_q   <= byte_i;
      start_q  <= start_i;
      length_q <= length_i;
    end
  end

  assign end_pos = SumW'(start_q) + SumW'(length_q);

  always_comb begin
    unique case (kind_q)
      KIND_APPEND:  bad = (len_q == LenW'(MAX_LEN));
      KIND_QUERY:   bad = (end_pos > SumW'(len_q));
      KIND_RESTART: bad = 1'b0;
      default:      bad = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cmd_i.clr_len) begin
      len_q <= '0;
    end else if (cmd_i.wr_power) begin
      len_q <= wr_addr;
    end
  end

  assign wr_addr = len_q + LenW'(1);

  // in range, addresses fit the length width
  always_comb begin
    if (kind_q == KIND_APPEND) begin
      lo_addr = len_q;
      pw_addr = len_q;
    end else begin
      lo_addr = LenW'(start_q);
      pw_addr = LenW'(length_q);
    end
    hi_addr = LenW'(end_pos);
  end

  // entry 0 is never written; it reads as zero / one
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_append) begin
      prefix_mem[wr_addr] <= fin_append;
    end
    if (cmd_i.rd) begin
      lo_raw_q  <= prefix_mem[lo_addr];
      hi_raw_q  <= prefix_mem[hi_addr];
      lo_zero_q <= (lo_addr == '0);
      hi_zero_q <= (hi_addr == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_power) begin
      power_mem[wr_addr] <= mul_p;
    end
    if (cmd_i.rd) begin
      pw_raw_q  <= power_mem[pw_addr];
      pw_zero_q <= (pw_addr == '0);
    end
  end

  assign pre_lo = lo_zero_q ? '0 : lo_raw_q;
  assign pre_hi = hi_zero_q ? '0 : hi_raw_q;
  assign pow    = pw_zero_q ? word_t'(1) : pw_raw_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MSEL_BASE_PREFIX: begin mul_x = base_q; mul_y = pre_lo; end
      MSEL_POWER_BASE:  begin mul_x = pow;    mul_y = base_q; end
      default:          begin mul_x = pre_lo; mul_y = pow;    end
    endcase
  end

  rhm61_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  assign fin_append = fold61({3'b0, mul_p} + {56'b0, byte_q});
  assign fin_query  = fold61({3'b0, pre_hi} + {3'b0, PRIME_M61} - {3'b0, mul_p});

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_append) begin
      res_q     <= fin_append;
      res_err_q <= 1'b0;
    end else if (cmd_i.res_query) begin
      res_q     <= fin_query;
      res_err_q <= 1'b0;
    end else if (cmd_i.res_zero) begin
      res_q     <= '0;
      res_err_q <= bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_hash_q <= res_q;
      out_err_q  <= res_err_q;
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.bad      = bad;
  assign sts_o.mul_done = mul_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_hash_o  = out_hash_q;
  assign out_err_o   = out_err_q;

endmodule

// ===== rtl/core/rolling_hash_mersenne61.sv =====
// Polynomial rolling hash mod 2^61-1 over a byte string kept in on-chip memory.
// An item appends one byte (returns the new prefix hash), queries a substring hash, or
// restarts the string (returns zero). Appending past MAX_LEN or querying past the stored
// length returns zero with range_error set; kind 3 does the same. One item is worked on
// at a time, and the shared 31x31 multiplier forms each 61-bit modular product (two
// products for an append, one for a query); every item also passes through the decode,
// output-load and idle states. A finished result sits in the output register, so the
// next item is taken while it waits.
// No clearing pass after reset: entry 0 of each store is a constant.
// Depends on rhm61_pkg, rhm61_ctrl, rhm61_dp.
module rolling_hash_mersenne61 #(
  parameter int unsigned MAX_LEN = rhm61_pkg::RHM_MAX_LEN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [60:0] cfg_data_i,     // hash_base
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // byte_value[7:0], start_pos[20:8], sub_length[33:21]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // hash_value[60:0]
  output logic [0:0]  m_axis_tuser    // range_error[0]
);
  import rhm61_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  word_t out_hash;
  logic  out_err;

  rhm61_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rhm61_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (s_axis_tuser),
    .byte_i      (s_axis_tdata[7:0]),
    .start_i     (s_axis_tdata[20:8]),
    .length_i    (s_axis_tdata[33:21]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_hash_o  (out_hash),
    .out_err_o   (out_err)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {3'b0, out_hash};
  assign m_axis_tuser = out_err;

endmodule

// ===== rtl/core/rhm61_chk.sv =====
// Port-level checker for rolling_hash_mersenne61, bound to the top level.
// Depends on rolling_hash_mersenne61_macros.svh.
`include "rolling_hash_mersenne61_macros.svh"

module rhm61_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // a stalled result holds
  `RHM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // refused items carry a zero hash
  `RHM_ASSERT_IMPLY(a_err_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 64'd0)

  // hash is always reduced below P
  `RHM_ASSERT_IMPLY(a_reduced, m_axis_tvalid, m_axis_tdata[63:61] == 3'd0 && m_axis_tdata[60:0] != {61{1'b1}})

  // one item at a time: no accept right after an accept
  `RHM_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind rolling_hash_mersenne61 rhm61_chk u_rhm61_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for rolling_hash_mersenne61: append/query/restart items on the input
// stream, results checked against an in-bench mod 2^61-1 hash predictor. Uses rhm61_pkg.
module tb_top;
  import rhm61_pkg::*;

  localparam int unsigned MAX_LEN        = RHM_MAX_LEN;
  localparam logic [1:0]  KIND_UNUSED    = 2'd3;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_v;
    logic [12:0] start;
    logic [12:0] len;
  } hash_item_t;

  typedef struct packed {
    word_t hash;
    logic  err;
  } hash_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  word_t       cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  rolling_hash_mersenne61 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  word_t        hash_base_q = BASE_RESET;
  word_t        prefix_hash [0:MAX_LEN];
  word_t        base_power  [0:MAX_LEN];
  int unsigned  str_len     = 0;
  int unsigned  longest_len = 0;

  hash_item_t   items_to_send [$];
  hash_result_t results_due   [$];
  hash_item_t   next_item;
  int unsigned  gen_len       = 0;   // string length as seen by the item generator

  bit           item_taken    = 1'b0;
  int unsigned  stall_pct     = 0;
  int unsigned  send_gap      = 0;
  int unsigned  hold_left     = 0;
  int unsigned  hold_asks     = 0;
  int unsigned  hold_served   = 0;
  int unsigned  quiet_cycles  = 0;

  int unsigned  mismatches    = 0;
  int unsigned  n_append = 0, n_query = 0, n_restart = 0, n_unused = 0;
  int unsigned  n_results = 0, n_refused = 0, n_bases = 1;

  function automatic word_t add_mod(word_t a, word_t b);
    logic [61:0] s;
    s = a + b;
    if (s >= {1'b0, PRIME_M61}) s = s - {1'b0, PRIME_M61};
    return s[60:0];
  endfunction

  function automatic word_t sub_mod(word_t a, word_t b);
    logic [61:0] d;
    d = {1'b0, a} + {1'b0, PRIME_M61} - {1'b0, b};
    if (d >= {1'b0, PRIME_M61}) d = d - {1'b0, PRIME_M61};
    return d[60:0];
  endfunction

  // full 122-bit product, folded once and then reduced by subtraction since 2^61 = 1 mod P
  function automatic word_t mul_mod(word_t a, word_t b);
    logic [121:0] prod;
    logic [62:0]  s;
    prod = a * b;
    s = prod[121:61] + prod[60:0];
    while (s >= {2'b00, PRIME_M61}) s = s - {2'b00, PRIME_M61};
    return s[60:0];
  endfunction

  function automatic hash_result_t predict_hash(logic [1:0] kind, logic [7:0] byte_v,
                                                logic [12:0] start, logic [12:0] len);
    hash_result_t r;
    word_t        b_eff;
    int unsigned  end_pos;
    r.hash = '0;
    r.err  = 1'b0;
    case (kind)
      KIND_APPEND: begin
        n_append++;
        if (str_len >= MAX_LEN) begin
          r.err = 1'b1;
        end else begin
          // all-ones base register is P itself, i.e. zero
          b_eff = (hash_base_q == PRIME_M61) ? '0 : hash_base_q;
          r.hash = add_mod(mul_mod(b_eff, prefix_hash[str_len]), word_t'(byte_v));
          prefix_hash[str_len+1] = r.hash;
          base_power[str_len+1]  = mul_mod(base_power[str_len], b_eff);
          str_len++;
          if (str_len > longest_len) longest_len = str_len;
        end
      end
      KIND_QUERY: begin
        n_query++;
        end_pos = start + len;
        if (end_pos > str_len) r.err = 1'b1;
        else r.hash = sub_mod(prefix_hash[end_pos], mul_mod(prefix_hash[start], base_power[len]));
      end
      KIND_RESTART: begin
        n_restart++;
        str_len = 0;
      end
      default: begin
        n_unused++;
        r.err = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  task automatic add_item(logic [1:0] kind, logic [7:0] byte_v, logic [12:0] start,
                          logic [12:0] len);
    items_to_send.push_back('{kind: kind, byte_v: byte_v, start: start, len: len});
    if (kind == KIND_APPEND && gen_len < MAX_LEN) gen_len++;
    else if (kind == KIND_RESTART) gen_len = 0;
  endtask

  // mostly appends and in-range queries, with some refused and noise items
  task automatic random_items(int unsigned n);
    int unsigned pick, s, l;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        add_item(KIND_APPEND, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)),
                 13'($urandom_range(0, 8191)));
      end else if (pick < 80) begin
        s = (gen_len == 0) ? 0 : $urandom_range(0, gen_len);
        l = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - s);
        add_item(KIND_QUERY, 8'($urandom_range(0, 255)), 13'(s), 13'(l));
      end else if (pick < 88) begin
        add_item(KIND_QUERY, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)),
                 13'($urandom_range(0, 8191)));
      end else if (pick < 92) begin
        add_item(KIND_RESTART, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)),
                 13'($urandom_range(0, 8191)));
      end else begin
        add_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)),
                 13'($urandom_range(0, 8191)));
      end
    end
  endtask

  task automatic wait_idle();
    while (items_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_base(word_t v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    hash_base_q = v;
    n_bases++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic word_t rand_base();
    logic [31:0] hi, lo;
    word_t       v;
    hi = $urandom;
    lo = $urandom;
    v = {hi[28:0], lo};
    if (v < 2) v = 2;
    if (v > PRIME_M61 - 2) v = PRIME_M61 - 2;
    return v;
  endfunction

  // input side: present items, keep tvalid up until taken
  always @(negedge clk_i) begin
    if (rst_ni && (item_taken || !s_axis_tvalid)) begin
      item_taken = 1'b0;
      if (send_gap == 0 && $urandom_range(1, 100) <= stall_pct)
        send_gap = $urandom_range(1, 15);
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        next_item = items_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, next_item.len, next_item.start, next_item.byte_v};
        s_axis_tuser  <= next_item.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      results_due.push_back(predict_hash(s_axis_tuser, s_axis_tdata[7:0],
                                         s_axis_tdata[20:8], s_axis_tdata[33:21]));
      item_taken = 1'b1;
    end
  end

  // output side: random stalls, plus one long hold on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left   = LONG_HOLD;
      end else if (hold_left == 0 && $urandom_range(1, 100) <= stall_pct) begin
        hold_left = $urandom_range(1, 15);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (m_axis_tuser[0]) n_refused++;
      if (results_due.size() == 0) begin
        note_mismatch("unexpected result", '0, {m_axis_tuser[0], m_axis_tdata[62:0]});
      end else begin
        if (m_axis_tdata[60:0] !== results_due[0].hash)
          note_mismatch("hash_value", results_due[0].hash, m_axis_tdata[60:0]);
        if (m_axis_tuser[0] !== results_due[0].err)
          note_mismatch("range_error", results_due[0].err, m_axis_tuser[0]);
        void'(results_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    prefix_hash[0] = '0;
    base_power[0]  = word_t'(1);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset base, directed corners
    stall_pct = 20;
    add_item(KIND_QUERY,   8'h00, 0, 0);          // empty query on empty string
    add_item(KIND_QUERY,   8'h00, 0, 1);
    add_item(KIND_APPEND,  8'h00, 0, 0);
    add_item(KIND_APPEND,  8'hFF, 0, 0);
    add_item(KIND_APPEND,  8'hA5, 0, 0);
    add_item(KIND_APPEND,  8'h5A, 0, 0);
    add_item(KIND_QUERY,   8'h00, 0, 4);
    add_item(KIND_QUERY,   8'h00, 1, 2);
    add_item(KIND_QUERY,   8'h00, 4, 0);
    add_item(KIND_QUERY,   8'h00, 3, 2);
    add_item(KIND_UNUSED,  8'hFF, 13'h1FFF, 13'h1FFF);
    add_item(KIND_QUERY,   8'hFF, 13'h1FFF, 13'h1FFF);
    add_item(KIND_QUERY,   8'h00, 4096, 0);
    add_item(KIND_APPEND,  8'h01, 13'h1FFF, 13'h1FFF);
    add_item(KIND_QUERY,   8'h00, 0, 5);
    add_item(KIND_RESTART, 8'hFF, 13'h1FFF, 13'h1FFF);
    add_item(KIND_QUERY,   8'h00, 0, 0);
    add_item(KIND_QUERY,   8'h00, 0, 1);
    add_item(KIND_APPEND,  8'h80, 0, 0);
    add_item(KIND_APPEND,  8'h7F, 0, 0);
    add_item(KIND_QUERY,   8'h00, 0, 2);
    add_item(KIND_QUERY,   8'h00, 1, 1);
    wait_idle();

    // base P-2 without restart: stored prefixes keep the old base
    write_base(PRIME_M61 - 2);
    stall_pct = 15;
    add_item(KIND_APPEND, 8'h33, 0, 0);
    add_item(KIND_QUERY,  8'h00, 0, 3);
    add_item(KIND_QUERY,  8'h00, 2, 1);
    random_items(80);
    hold_asks++;  // block fills up behind a stuck output
    wait_idle();

    write_base(word_t'(2));
    stall_pct = 30;
    random_items(80);
    wait_idle();

    write_base('0);
    stall_pct = 0;
    random_items(40);
    wait_idle();

    write_base(word_t'(1));
    stall_pct = 10;
    random_items(40);
    wait_idle();

    write_base(PRIME_M61);   // reduces to zero
    stall_pct = 25;
    random_items(40);
    wait_idle();

    // a longer fresh string, then queries at and past its end
    write_base(rand_base());
    stall_pct = 8;
    add_item(KIND_RESTART, 8'h00, 0, 0);
    repeat (60)
      add_item(KIND_APPEND, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)),
               13'($urandom_range(0, 8191)));
    add_item(KIND_APPEND, 8'hFF, 0, 0);
    add_item(KIND_APPEND, 8'h00, 0, 0);
    add_item(KIND_QUERY,  8'h00, 0, 62);
    add_item(KIND_QUERY,  8'h00, 62, 0);
    add_item(KIND_QUERY,  8'h00, 61, 1);
    add_item(KIND_QUERY,  8'h00, 31, 31);
    add_item(KIND_QUERY,  8'h00, 62, 1);
    add_item(KIND_QUERY,  8'h00, 0, 63);
    add_item(KIND_QUERY,  8'h00, 1, 4096);
    random_items(40);
    wait_idle();

    write_base(rand_base());
    stall_pct = 0;
    random_items(100);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("summary: %0d appends, %0d queries, %0d restarts, %0d unused-kind items",
             n_append, n_query, n_restart, n_unused);
    $display("summary: %0d results (%0d refused), %0d base settings, longest string %0d",
             n_results, n_refused, n_bases, longest_len);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, results_due.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== rolling_hash_mersenne61.f =====
+incdir+rtl/core
rtl/core/rhm61_pkg.sv
rtl/core/rhm61_mul.sv
rtl/core/rhm61_ctrl.sv
rtl/core/rhm61_dp.sv
rtl/core/rolling_hash_mersenne61.sv
rtl/core/rhm61_chk.sv
tb/sv/tb_top.sv
